/* rtl/nbhc_pkg.sv */
// Shared types, constants and coefficient tables for the NbTi specific heat pipeline.
package nbhc_pkg;

  // Field and datapath widths.
  localparam int unsigned TempW    = 20;
  localparam int unsigned TempFracW = 10;
  localparam int unsigned FieldW   = 13;
  localparam int unsigned HeatW    = 24;
  localparam int unsigned AccW     = 64;
  localparam int unsigned FracW    = 32;
  localparam int unsigned FieldShift = FracW - 2;

  // Polynomial shape.
  localparam int unsigned NumRanges   = 6;
  localparam int unsigned NumCoefs    = 5;
  localparam int unsigned HornerSteps = NumCoefs - 1;

  typedef logic [2:0] nbhc_range_t;
  typedef logic [2:0] nbhc_cidx_t;

  localparam nbhc_range_t RangeLow  = 3'd0;
  localparam nbhc_cidx_t  LinearIdx = 3'd1;
  localparam nbhc_cidx_t  TopIdx    = 3'd4;

  // Range breakpoints on the raw temperature (T >= breakpoint).
  localparam logic [TempW-1:0] Brk1 = 20'd9626;
  localparam logic [TempW-1:0] Brk2 = 20'd29039;
  localparam logic [TempW-1:0] Brk3 = 20'd52214;
  localparam logic [TempW-1:0] Brk4 = 20'd169780;
  localparam logic [TempW-1:0] Brk5 = 20'd508457;

  // Output scaling: q = floor((P + D/2) / D) with D = density * 2^24.
  localparam logic [63:0] Density  = 64'd6538;
  localparam int unsigned DenShift = 24;
  localparam int unsigned HalfW    = 36;
  localparam logic [HalfW-1:0] HalfDen = HalfW'(Density << (DenShift - 1));

  // Quotient by reciprocal multiply, exact for dividends below 2^XW.
  localparam int unsigned XW        = 38;
  localparam int unsigned SplitW    = XW / 2;
  localparam int unsigned RecipW    = 39;
  localparam int unsigned RecipShift = 51;
  localparam logic [RecipW-1:0] Recip =
      RecipW'(((64'd1 << RecipShift) + Density - 64'd1) / Density);
  localparam int unsigned ProdW = SplitW + RecipW;
  localparam int unsigned TotW  = ProdW + SplitW;
  localparam int unsigned QW    = TotW - RecipShift;

  localparam logic [HeatW-1:0] HeatMax = '1;

  // Coefficient k of range r multiplies T^k, in Q.32, rounded half away from zero.
  localparam logic signed [AccW-1:0] Coef [NumRanges][NumCoefs] = '{
    '{ 64'sd0,
       64'sd0,
       64'sd0,
       $signed(((64'd491 << 32) + 64'd5) / 64'd10),
       64'sd0 },
    '{ 64'sd0,
       $signed(64'd928 << 32),
       64'sd0,
       $signed(((64'd1624 << 32) + 64'd50) / 64'd100),
       64'sd0 },
    '{ $signed(64'd41383 << 32),
       -$signed(((64'd78461 << 32) + 64'd5) / 64'd10),
       $signed(((64'd55371 << 32) + 64'd50) / 64'd100),
       $signed(((64'd119838 << 32) + 64'd5000) / 64'd10000),
       -$signed(((64'd2177 << 32) + 64'd5000) / 64'd10000) },
    '{ -$signed(64'd1530000 << 32),
       $signed(64'd83022 << 32),
       -$signed(((64'd7163 << 32) + 64'd5) / 64'd10),
       $signed(((64'd2976 << 32) + 64'd500) / 64'd1000),
       -$signed(((64'd482 << 32) + 64'd50000) / 64'd100000) },
    '{ $signed(64'd1240000 << 32),
       $signed(64'd13706 << 32),
       -$signed(((64'd5166 << 32) + 64'd50) / 64'd100),
       $signed(((64'd9296 << 32) + 64'd50000) / 64'd100000),
       -$signed(((64'd629 << 32) + 64'd5000000) / 64'd10000000) },
    '{ $signed(64'd2450000 << 32),
       $signed(((64'd9555 << 32) + 64'd5) / 64'd10),
       -$signed(((64'd257 << 32) + 64'd500) / 64'd1000),
       64'sd0,
       64'sd0 }
  };

  // One sample as it travels down the chain.
  typedef struct packed {
    logic [TempW-1:0]       temperature;
    nbhc_range_t            rng;
    logic                   zero;
    logic signed [AccW-1:0] acc;
  } nbhc_item_t;

  // Table lookup; codes outside the table read as zero.
  function automatic logic signed [AccW-1:0] coef_of(nbhc_range_t r, nbhc_cidx_t k);
    logic signed [AccW-1:0] c;
    c = '0;
    if (r < 3'(NumRanges) && k < 3'(NumCoefs)) begin
      c = Coef[r][k];
    end
    return c;
  endfunction

endpackage

/* rtl/nbhc_range.sv */
// Front stage: picks the temperature range and seeds the Horner accumulator.
module nbhc_range
  import nbhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TempW-1:0] in_temp_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nbhc_item_t       out_item_o
);

  logic        v_q;
  nbhc_item_t  item_q, item_d;
  nbhc_range_t rng;

  assign in_ready_o = !v_q || out_ready_i;

  // Breakpoint compares, lowest range first.
  always_comb begin
    priority if (in_temp_i < Brk1) begin
      rng = 3'd0;
    end else if (in_temp_i < Brk2) begin
      rng = 3'd1;
    end else if (in_temp_i < Brk3) begin
      rng = 3'd2;
    end else if (in_temp_i < Brk4) begin
      rng = 3'd3;
    end else if (in_temp_i < Brk5) begin
      rng = 3'd4;
    end else begin
      rng = 3'd5;
    end
  end

  always_comb begin
    item_d.temperature = in_temp_i;
    item_d.rng         = rng;
    item_d.zero        = (in_temp_i == '0);
    item_d.acc         = coef_of(rng, TopIdx);
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_item_o  = item_q;

  a_low_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && item_q.rng == RangeLow |-> item_q.temperature < Brk1)
    else $error("low range tagged on a temperature above the first breakpoint");

endmodule

/* rtl/nbhc_cell.sv */
// One Horner cell: acc <- floor(acc * T / 1024) + c[K], in two register stages.
module nbhc_cell
  import nbhc_pkg::*;
#(
  parameter int unsigned K = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FieldW-1:0] field_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nbhc_item_t        in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nbhc_item_t        out_item_o
);

  localparam int unsigned LoW = FracW + TempW;
  localparam int unsigned HiW = AccW - FracW + TempW + 1;

  logic                   v1_q, v2_q;
  logic                   ready1, ready2;
  nbhc_item_t             item1_q, item2_q;
  logic [LoW-1:0]         lo_q, lo_d;
  logic signed [HiW-1:0]  hi_q, hi_d;
  logic signed [AccW-1:0] coef_q, coef_d;
  logic signed [AccW-1:0] acc_d;

  assign ready2     = !v2_q || out_ready_i;
  assign ready1     = !v1_q || ready2;
  assign in_ready_o = ready1;

  // Stage 1: the two partial products of the 64 x 20 multiply and the coefficient.
  always_comb begin
    lo_d = LoW'(in_item_i.acc[FracW-1:0]) * LoW'(in_item_i.temperature);
    hi_d = $signed(in_item_i.acc[AccW-1:FracW]) * $signed({1'b0, in_item_i.temperature});
    if (in_item_i.rng == RangeLow && 3'(K) == LinearIdx) begin
      coef_d = $signed({{(AccW - FieldW - FieldShift){1'b0}}, field_i,
                        {FieldShift{1'b0}}});
    end else begin
      coef_d = coef_of(in_item_i.rng, 3'(K));
    end
  end

  // Stage 2: recombine, drop the ten temperature fraction bits, add the coefficient.
  assign acc_d = (AccW'(hi_q) <<< (FracW - TempFracW))
               + $signed(AccW'(lo_q[LoW-1:TempFracW]))
               + coef_q;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (ready1 && in_valid_i) begin
      item1_q <= in_item_i;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      coef_q  <= coef_d;
    end
    if (ready2 && v1_q) begin
      item2_q <= {item1_q.temperature, item1_q.rng, item1_q.zero, acc_d};
    end
  end

  assign out_valid_o = v2_q;
  assign out_item_o  = item2_q;

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && ready2 |=> v2_q)
    else $error("word left the product stage but did not reach the sum stage");

endmodule

/* rtl/nbhc_scale.sv */
// Back end: divides by the density with rounding, clamps and saturates.
module nbhc_scale
  import nbhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  nbhc_item_t       in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [HeatW-1:0] out_heat_o,
  output logic             out_sat_o
);

  typedef struct packed {
    logic zero;
    logic neg;
    logic big;
  } nbhc_flags_t;

  logic              v1_q, v2_q, v3_q;
  logic              ready1, ready2, ready3;
  nbhc_flags_t       flags_d, flags1_q, flags2_q;
  logic [XW+DenShift-1:0] sum_d;
  logic [XW-1:0]     x1_q;
  logic [ProdW-1:0]  ph_q, pl_q;
  logic [TotW-1:0]   total;
  logic [QW-1:0]     q;
  logic [HeatW-1:0]  heat_d, heat_q;
  logic              sat_d, sat_q;

  assign ready3     = !v3_q || out_ready_i;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_ready_o = ready1;

  // Stage 1: rounding offset and the first power-of-two part of the divide.
  always_comb begin
    flags_d.zero = in_item_i.zero;
    flags_d.neg  = in_item_i.acc[AccW-1];
    flags_d.big  = |in_item_i.acc[AccW-2:XW+DenShift-1];
    sum_d = {1'b0, in_item_i.acc[XW+DenShift-2:0]} + (XW + DenShift)'(HalfDen);
  end

  // Stage 3: reassemble the reciprocal product and pick the result.
  assign total = {ph_q, {SplitW{1'b0}}} + TotW'(pl_q);
  assign q     = total[TotW-1:RecipShift];

  always_comb begin
    heat_d = '0;
    sat_d  = 1'b0;
    priority if (flags2_q.zero) begin
      heat_d = '0;
      sat_d  = 1'b0;
    end else if (flags2_q.neg) begin
      heat_d = '0;
      sat_d  = 1'b1;
    end else if (flags2_q.big || (|q[QW-1:HeatW])) begin
      heat_d = HeatMax;
      sat_d  = 1'b1;
    end else begin
      heat_d = q[HeatW-1:0];
      sat_d  = 1'b0;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Payload; stage 2 multiplies both halves of the dividend by the reciprocal.
  always_ff @(posedge clk_i) begin
    if (ready1 && in_valid_i) begin
      flags1_q <= flags_d;
      x1_q     <= sum_d[XW+DenShift-1:DenShift];
    end
    if (ready2 && v1_q) begin
      flags2_q <= flags1_q;
      ph_q     <= ProdW'(x1_q[XW-1:SplitW]) * ProdW'(Recip);
      pl_q     <= ProdW'(x1_q[SplitW-1:0]) * ProdW'(Recip);
    end
    if (ready3 && v2_q) begin
      heat_q <= heat_d;
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_heat_o  = heat_q;
  assign out_sat_o   = sat_q;

  a_sat_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && sat_q |-> heat_q == '0 || heat_q == HeatMax)
    else $error("saturated word carries a value inside the range");

  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready3 && v2_q && flags2_q.zero |=> v3_q && !sat_q && heat_q == '0)
    else $error("zero temperature did not give a clean zero");

endmodule

/* rtl/nbti_heat_capacity_piecewise_poly.sv */
// Top level of the NbTi specific heat evaluator.
// Each input word carries one temperature in 1/1024 K; each output word carries the
// specific heat in 1/256 J/(kg K) and a flag that is set when the value was clamped
// at zero or saturated at the maximum. The block takes one word per clock cycle while
// the output is not stalled and returns results in order, through one register stage
// for the range select, two for each of the four Horner cells in the chain (a 64 x 20
// multiply split into two partial products, then the sum), and three for the rounding
// divide by the density. Output stalls back up stage by stage,
// so a waiting result does not block new words until the chain is full. The field
// register may be written only while no word is in flight.
module nbti_heat_capacity_piecewise_poly
  import nbhc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [FieldW-1:0] cfg_wr_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // [19:0] temperature
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata    // [23:0] specific_heat, [24] saturated
);

  logic [FieldW-1:0] field_q;
  logic              valid_s [HornerSteps+1];
  logic              ready_s [HornerSteps+1];
  nbhc_item_t        item_s  [HornerSteps+1];
  logic [HeatW-1:0]  heat;
  logic              sat;

  // Field register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= '0;
    end else if (cfg_wr_en_i) begin
      field_q <= cfg_wr_data_i;
    end
  end

  nbhc_range u_range (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_temp_i   (s_axis_tdata[TempW-1:0]),
    .out_valid_o (valid_s[0]),
    .out_ready_i (ready_s[0]),
    .out_item_o  (item_s[0])
  );

  // Horner chain, highest coefficient first.
  for (genvar j = 0; j < HornerSteps; j++) begin : g_cell
    nbhc_cell #(
      .K (HornerSteps - 1 - j)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .field_i     (field_q),
      .in_valid_i  (valid_s[j]),
      .in_ready_o  (ready_s[j]),
      .in_item_i   (item_s[j]),
      .out_valid_o (valid_s[j+1]),
      .out_ready_i (ready_s[j+1]),
      .out_item_o  (item_s[j+1])
    );
  end

  nbhc_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_s[HornerSteps]),
    .in_ready_o  (ready_s[HornerSteps]),
    .in_item_i   (item_s[HornerSteps]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_heat_o  (heat),
    .out_sat_o   (sat)
  );

  assign m_axis_tdata = {{(32 - HeatW - 1){1'b0}}, sat, heat};

endmodule

/* tb/sv/nbti_heat_capacity_piecewise_poly_test.sv */
// Self-checking testbench for the NbTi specific heat pipeline.
module nbti_heat_capacity_piecewise_poly_test;
  import nbhc_pkg::*;

  localparam int unsigned HalfPeriod = 2;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned RandomWords = 280;
  localparam logic [TempW-1:0] TempMax = '1;
  localparam logic [FieldW-1:0] FieldMax = '1;
  localparam logic [FieldW-1:0] FieldRated = 13'd5120;
  localparam int unsigned NumEdges = 5;

  // Lower bound of each range above the first, on the raw temperature.
  localparam int unsigned RangeEdge [NumEdges] = '{9626, 29039, 52214, 169780, 508457};

  typedef struct packed {
    logic [HeatW-1:0] heat;
    logic             sat;
  } heat_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_wr_en_i;
  logic [FieldW-1:0] cfg_wr_data_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata;   // [19:0] temperature
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [31:0]       m_axis_tdata;   // [23:0] specific_heat, [24] saturated

  heat_result_t      heat_queue[$];
  logic [FieldW-1:0] field_now;
  int unsigned       error_count;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       hold_requests;
  int unsigned       hold_served;
  int unsigned       hold_left;

  nbti_heat_capacity_piecewise_poly DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  // Decimal n/d in Q.32, ties rounded away from zero.
  function automatic longint q32(longint n, longint d);
    return ((n <<< 32) + d / 2) / d;
  endfunction

  // Coefficient of T^k in range r; the linear term of the lowest range follows the field.
  function automatic longint poly_coef(int r, int k, logic [FieldW-1:0] field);
    longint c;
    c = 0;
    case (r)
      0: case (k)
        1: c = longint'(field) <<< 30;
        3: c = q32(491, 10);
        default: c = 0;
      endcase
      1: case (k)
        1: c = q32(928, 1);
        3: c = q32(1624, 100);
        default: c = 0;
      endcase
      2: case (k)
        0: c = q32(41383, 1);
        1: c = -q32(78461, 10);
        2: c = q32(55371, 100);
        3: c = q32(119838, 10000);
        default: c = -q32(2177, 10000);
      endcase
      3: case (k)
        0: c = -q32(1530000, 1);
        1: c = q32(83022, 1);
        2: c = -q32(7163, 10);
        3: c = q32(2976, 1000);
        default: c = -q32(482, 100000);
      endcase
      4: case (k)
        0: c = q32(1240000, 1);
        1: c = q32(13706, 1);
        2: c = -q32(5166, 100);
        3: c = q32(9296, 100000);
        default: c = -q32(629, 10000000);
      endcase
      default: case (k)
        0: c = q32(2450000, 1);
        1: c = q32(9555, 10);
        2: c = -q32(257, 1000);
        default: c = 0;
      endcase
    endcase
    return c;
  endfunction

  // Specific heat for one temperature: Horner in Q.32, then rounded divide by the density.
  function automatic heat_result_t predict_heat(logic [TempW-1:0] t, logic [FieldW-1:0] field);
    heat_result_t res;
    logic signed [95:0] wide_acc;
    logic signed [95:0] wide_t;
    logic signed [95:0] prod;
    longint acc;
    longint den;
    longint q;
    int r;
    res = '0;
    if (t == '0) begin
      return res;
    end
    r = 0;
    for (int i = 0; i < NumEdges; i++) begin
      if (t >= RangeEdge[i]) r = i + 1;
    end
    acc = poly_coef(r, 4, field);
    wide_t = $signed({76'd0, t});
    for (int k = 3; k >= 0; k--) begin
      wide_acc = acc;
      prod = (wide_acc * wide_t) >>> 10;
      acc = longint'(prod[63:0]) + poly_coef(r, k, field);
    end
    if (acc < 0) begin
      res.sat = 1'b1;
      return res;
    end
    den = longint'(6538) <<< 24;
    q = (acc + den / 2) / den;
    if (q > longint'(HeatMax)) begin
      res.heat = HeatMax;
      res.sat = 1'b1;
    end else begin
      res.heat = q[HeatW-1:0];
    end
    return res;
  endfunction

  // Offer one temperature word, with random idle cycles ahead of it.
  task automatic send_temp(logic [TempW-1:0] t);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {4'd0, t};
    do @(posedge clk_i); while (!s_axis_tready);
    heat_queue.push_back(predict_heat(t, field_now));
  endtask

  // Drop valid once the last word of a burst has gone.
  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_for_results();
    while (heat_queue.size() != 0) @(posedge clk_i);
  endtask

  // Field writes happen only with the pipeline empty and settled.
  task automatic write_field(logic [FieldW-1:0] field);
    wait_for_results();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_wr_en_i = 1'b1;
    cfg_wr_data_i = field;
    field_now = field;
    @(negedge clk_i);
    cfg_wr_en_i = 1'b0;
  endtask

  // Mostly in-range temperatures, uniform over the six ranges, plus edges and extremes.
  function automatic logic [TempW-1:0] pick_temp();
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(9))
      0: return TempW'($urandom_range(TempMax));
      1: return TempW'(RangeEdge[$urandom_range(NumEdges - 1)] + $urandom_range(6) - 3);
      2: return TempW'($urandom_range(16));
      3: return TempMax - TempW'($urandom_range(16));
      default: begin
        r = $urandom_range(NumEdges);
        lo = (r == 0) ? 1 : RangeEdge[r-1];
        hi = (r == NumEdges) ? TempMax : RangeEdge[r] - 1;
        return TempW'($urandom_range(hi, lo));
      end
    endcase
  endfunction

  // Edges of every range, zero, full scale and the field extremes.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_temp('0);
    send_temp(20'd1);
    foreach (RangeEdge[i]) begin
      send_temp(TempW'(RangeEdge[i] - 1));
      send_temp(TempW'(RangeEdge[i]));
    end
    send_temp(TempMax);
    send_temp(20'h55555);
    send_temp(20'hAAAAA);
    end_burst();
    write_field(FieldMax);
    send_temp(20'd1);
    send_temp(20'd5000);
    send_temp(TempW'(RangeEdge[0] - 1));
    send_temp(TempW'(RangeEdge[0]));
    end_burst();
    write_field(FieldRated);
    send_temp(20'd1);
    send_temp(20'd2048);
    send_temp(TempW'(RangeEdge[0] - 1));
    end_burst();
  endtask

  task automatic test_random(int unsigned s_pct, int unsigned r_pct, logic [FieldW-1:0] field);
    write_field(field);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (RandomWords) send_temp(pick_temp());
    end_burst();
  endtask

  // Receiver holds off long enough that the chain fills and stalls the input.
  task automatic test_backpressure();
    write_field(13'($urandom_range(FieldMax)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk_i);
    hold_requests++;
    repeat (40) send_temp(pick_temp());
    end_burst();
  endtask

  // Sender stops mid-stream until every pending result is out, then resumes.
  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_idle_pct = 30;
    repeat (20) send_temp(pick_temp());
    end_burst();
    wait_for_results();
    repeat (20) send_temp(pick_temp());
    end_burst();
  endtask

  // Receiver ready: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each delivered word with the oldest prediction.
  always @(posedge clk_i) begin
    heat_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (heat_queue.size() == 0) begin
        $display("%0t unexpected result word: heat %0d sat %0b", $time,
                 m_axis_tdata[23:0], m_axis_tdata[24]);
        error_count++;
      end else begin
        exp_res = heat_queue.pop_front();
        if (m_axis_tdata[23:0] !== exp_res.heat) begin
          $display("%0t specific_heat mismatch: expected %0d, actual %0d", $time,
                   exp_res.heat, m_axis_tdata[23:0]);
          error_count++;
        end
        if (m_axis_tdata[24] !== exp_res.sat) begin
          $display("%0t saturated mismatch: expected %0b, actual %0b", $time,
                   exp_res.sat, m_axis_tdata[24]);
          error_count++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #2000000;
    $display("[nbti_heat_capacity_piecewise_poly] ERROR");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_ni = 1'b0;
    cfg_wr_en_i = 1'b0;
    cfg_wr_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    field_now = '0;
    error_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(18, 61, '0);
    test_random(61, 18, FieldMax);
    test_random(0, 0, 13'($urandom_range(FieldMax)));
    test_backpressure();
    test_drain_pause();

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[nbti_heat_capacity_piecewise_poly] OK");
    end else begin
      $display("[nbti_heat_capacity_piecewise_poly] ERROR");
    end
    $finish;
  end

endmodule

/* nbti_heat_capacity_piecewise_poly.f */
rtl/nbhc_pkg.sv
rtl/nbhc_range.sv
rtl/nbhc_cell.sv
rtl/nbhc_scale.sv
rtl/nbti_heat_capacity_piecewise_poly.sv
tb/sv/nbti_heat_capacity_piecewise_poly_test.sv
